// ----- rtl/core/scft_pkg.sv -----
// Shared types, constants and frame helpers for the serial command frame transmitter.
`timescale 1ns / 1ps

package scft_pkg;

   localparam int unsigned TickWidth = 16;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned PhaseWidth = 4;
   localparam int unsigned PosWidth = 3;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned QueueCountWidth = 2;

   localparam logic [TickWidth-1:0] TicksReset = 16'd14;

   localparam logic [PhaseWidth-1:0] PhaseStart = 4'd0;
   localparam logic [PhaseWidth-1:0] PhaseFirstData = 4'd1;
   localparam logic [PhaseWidth-1:0] PhaseLastData = 4'd8;
   localparam logic [PhaseWidth-1:0] PhaseStop = 4'd9;
   localparam logic [PosWidth-1:0] FirstByte = 3'd0;
   localparam logic [PosWidth-1:0] LastByte = 3'd7;

   localparam logic [ByteWidth-1:0] FrameSync = 8'h7E;
   localparam logic [ByteWidth-1:0] FrameVersion = 8'hFF;
   localparam logic [ByteWidth-1:0] FrameLength = 8'h06;
   localparam logic [ByteWidth-1:0] FrameZero = 8'h00;
   localparam logic [ByteWidth-1:0] FrameEnd = 8'hEF;

   localparam logic FuncTick = 1'b0;
   localparam logic FuncSend = 1'b1;

   typedef enum logic [1:0] {
      REG_START_TICKS = 2'd0,
      REG_BIT_TICKS = 2'd1,
      REG_STOP_TICKS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [TickWidth-1:0] start_ticks;
      logic [TickWidth-1:0] bit_ticks;
      logic [TickWidth-1:0] stop_ticks;
   } timing_type;

   typedef struct packed {
      logic tx_line;
      logic busy_res;
      logic accepted;
      logic frame_done;
   } result_type;

   function automatic logic [ByteWidth-1:0] frame_byte(
      input logic [PosWidth-1:0] pos,
      input logic [ByteWidth-1:0] command,
      input logic [ByteWidth-1:0] parameter_byte
   );
      logic [ByteWidth-1:0] value;
      case (pos)
         3'd0: value = FrameSync;
         3'd1: value = FrameVersion;
         3'd2: value = FrameLength;
         3'd3: value = command;
         3'd4: value = FrameZero;
         3'd5: value = FrameZero;
         3'd6: value = parameter_byte;
         default: value = FrameEnd;
      endcase
      return value;
   endfunction

endpackage

// ----- rtl/core/scft_csr.sv -----
// Timing register file behind the APB-style configuration port.
`timescale 1ns / 1ps

module scft_csr (
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [scft_pkg::CsrAddrWidth-1:0] csr_paddr,
   input logic [scft_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [scft_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic csr_pready,
   output scft_pkg::timing_type timing
);
   import scft_pkg::*;

   logic [TickWidth-1:0] start_ticks_ff;
   logic [TickWidth-1:0] bit_ticks_ff;
   logic [TickWidth-1:0] stop_ticks_ff;
   logic write_en;
   logic [TickWidth-1:0] read_value;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ticks_ff <= TicksReset;
         bit_ticks_ff <= TicksReset;
         stop_ticks_ff <= TicksReset;
      end else if (write_en) begin
         case (csr_paddr[3:2])
            REG_START_TICKS: start_ticks_ff <= csr_pwdata[TickWidth-1:0];
            REG_BIT_TICKS: bit_ticks_ff <= csr_pwdata[TickWidth-1:0];
            REG_STOP_TICKS: stop_ticks_ff <= csr_pwdata[TickWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_START_TICKS: read_value = start_ticks_ff;
         REG_BIT_TICKS: read_value = bit_ticks_ff;
         REG_STOP_TICKS: read_value = stop_ticks_ff;
         default: read_value = '0;
      endcase
   end

   assign csr_prdata = {{(CsrDataWidth-TickWidth){1'b0}}, read_value};

   assign timing.start_ticks = start_ticks_ff;
   assign timing.bit_ticks = bit_ticks_ff;
   assign timing.stop_ticks = stop_ticks_ff;

endmodule

// ----- rtl/core/scft_engine.sv -----
// Frame sequencer: bit timing, byte shifting and line level, one request per cycle while step is high.
`timescale 1ns / 1ps

module scft_engine (
   input logic clock,
   input logic reset,
   input logic step,
   input logic func,
   input logic [scft_pkg::ByteWidth-1:0] command,
   input logic [scft_pkg::ByteWidth-1:0] parameter_req,
   input scft_pkg::timing_type timing,
   output scft_pkg::result_type result
);
   import scft_pkg::*;

   logic sending_ff, sending_in;
   logic [PosWidth-1:0] byte_position_ff, byte_position_in;
   logic [PhaseWidth-1:0] bit_phase_ff, bit_phase_in;
   logic [TickWidth-1:0] tick_count_ff, tick_count_in;
   logic [ByteWidth-1:0] shift_byte_ff, shift_byte_in;
   logic [ByteWidth-1:0] held_command_ff, held_command_in;
   logic [ByteWidth-1:0] held_parameter_ff, held_parameter_in;
   logic line_level_ff, line_level_in;
   logic accepted;
   logic done;
   logic [TickWidth-1:0] tick_next;
   logic [TickWidth-1:0] phase_len;
   logic [ByteWidth-1:0] shifted;
   logic [PosWidth-1:0] next_position;

   always_comb begin
      if (bit_phase_ff == PhaseStart) begin
         phase_len = timing.start_ticks;
      end else if (bit_phase_ff <= PhaseLastData) begin
         phase_len = timing.bit_ticks;
      end else begin
         phase_len = timing.stop_ticks;
      end
      if (phase_len == '0) begin
         phase_len = {{(TickWidth-1){1'b0}}, 1'b1};
      end
   end

   assign tick_next = tick_count_ff + {{(TickWidth-1){1'b0}}, 1'b1};
   assign shifted = {1'b0, shift_byte_ff[ByteWidth-1:1]};
   assign next_position = byte_position_ff + {{(PosWidth-1){1'b0}}, 1'b1};

   always_comb begin
      sending_in = sending_ff;
      byte_position_in = byte_position_ff;
      bit_phase_in = bit_phase_ff;
      tick_count_in = tick_count_ff;
      shift_byte_in = shift_byte_ff;
      held_command_in = held_command_ff;
      held_parameter_in = held_parameter_ff;
      line_level_in = line_level_ff;
      accepted = 1'b0;
      done = 1'b0;
      if (func == FuncSend) begin
         if (!sending_ff) begin
            held_command_in = command;
            held_parameter_in = parameter_req;
            sending_in = 1'b1;
            byte_position_in = FirstByte;
            bit_phase_in = PhaseStart;
            tick_count_in = '0;
            shift_byte_in = FrameSync;
            line_level_in = 1'b0;
            accepted = 1'b1;
         end
      end else if (sending_ff) begin
         tick_count_in = tick_next;
         if (tick_next >= phase_len) begin
            tick_count_in = '0;
            if (bit_phase_ff == PhaseStart) begin
               bit_phase_in = PhaseFirstData;
               line_level_in = shift_byte_ff[0];
            end else if (bit_phase_ff < PhaseLastData) begin
               shift_byte_in = shifted;
               bit_phase_in = bit_phase_ff + {{(PhaseWidth-1){1'b0}}, 1'b1};
               line_level_in = shifted[0];
            end else if (bit_phase_ff == PhaseLastData) begin
               shift_byte_in = shifted;
               bit_phase_in = PhaseStop;
               line_level_in = 1'b1;
            end else if (byte_position_ff == LastByte) begin
               sending_in = 1'b0;
               byte_position_in = FirstByte;
               bit_phase_in = PhaseStart;
               line_level_in = 1'b1;
               done = 1'b1;
            end else begin
               byte_position_in = next_position;
               shift_byte_in = frame_byte(next_position, held_command_ff, held_parameter_ff);
               bit_phase_in = PhaseStart;
               line_level_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         byte_position_ff <= FirstByte;
         bit_phase_ff <= PhaseStart;
         tick_count_ff <= '0;
         shift_byte_ff <= '0;
         held_command_ff <= '0;
         held_parameter_ff <= '0;
         line_level_ff <= 1'b1;
      end else if (step) begin
         sending_ff <= sending_in;
         byte_position_ff <= byte_position_in;
         bit_phase_ff <= bit_phase_in;
         tick_count_ff <= tick_count_in;
         shift_byte_ff <= shift_byte_in;
         held_command_ff <= held_command_in;
         held_parameter_ff <= held_parameter_in;
         line_level_ff <= line_level_in;
      end
   end

   assign result.tx_line = line_level_in;
   assign result.busy_res = sending_in;
   assign result.accepted = accepted;
   assign result.frame_done = done;

endmodule

// ----- rtl/core/scft_outq.sv -----
// Two-entry result buffer that lets the engine run while the receiver stalls.
`timescale 1ns / 1ps

module scft_outq (
   input logic clock,
   input logic reset,
   input logic push,
   input scft_pkg::result_type push_data,
   output logic push_ready,
   output logic rsp_valid,
   input logic rsp_stall,
   output scft_pkg::result_type head
);
   import scft_pkg::*;

   logic [QueueCountWidth-1:0] count_ff;
   result_type slot0_ff;
   result_type slot1_ff;
   logic pop;

   assign rsp_valid = (count_ff != '0);
   assign pop = rsp_valid && !rsp_stall;
   assign push_ready = (count_ff != 2'd2) || pop;
   assign head = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push && !pop) begin
         count_ff <= count_ff + 2'd1;
      end else if (pop && !push) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (count_ff == 2'd2) begin
            slot0_ff <= slot1_ff;
            slot1_ff <= push_data;
         end else begin
            slot0_ff <= push_data;
         end
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end else if (push) begin
         if (count_ff == '0) begin
            slot0_ff <= push_data;
         end else begin
            slot1_ff <= push_data;
         end
      end
   end

endmodule

// ----- rtl/core/serial_command_frame_transmitter_core.sv -----
// A request passes the input register, then its result waits in the result buffer.
// Throughput: one request per cycle while the result buffer has room to take it.
// A two-entry result buffer keeps requests flowing while the result side stalls.
// Reset (synchronous, active high) idles the line high and sets all timing registers to 14.
// Top level of the serial command frame transmitter.
`timescale 1ns / 1ps

module serial_command_frame_transmitter_core (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_func,
   input logic [scft_pkg::ByteWidth-1:0] req_command,
   input logic [scft_pkg::ByteWidth-1:0] req_parameter_req,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_tx_line,
   output logic rsp_busy_res,
   output logic rsp_accepted,
   output logic rsp_frame_done,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [scft_pkg::CsrAddrWidth-1:0] csr_paddr,
   input logic [scft_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [scft_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic csr_pready
);
   import scft_pkg::*;

   logic in_valid_ff, in_valid_in;
   logic in_func_ff;
   logic [ByteWidth-1:0] in_command_ff;
   logic [ByteWidth-1:0] in_parameter_ff;
   logic req_take;
   logic step;
   logic push_ready;
   timing_type timing;
   result_type result;
   result_type head;

   assign step = in_valid_ff && push_ready;
   assign req_stall = in_valid_ff && !push_ready;
   assign req_take = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_command_ff <= req_command;
         in_parameter_ff <= req_parameter_req;
      end
   end

   scft_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .timing(timing)
   );

   scft_engine u_engine (
      .clock(clock),
      .reset(reset),
      .step(step),
      .func(in_func_ff),
      .command(in_command_ff),
      .parameter_req(in_parameter_ff),
      .timing(timing),
      .result(result)
   );

   scft_outq u_outq (
      .clock(clock),
      .reset(reset),
      .push(step),
      .push_data(result),
      .push_ready(push_ready),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .head(head)
   );

   assign rsp_tx_line = head.tx_line;
   assign rsp_busy_res = head.busy_res;
   assign rsp_accepted = head.accepted;
   assign rsp_frame_done = head.frame_done;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the serial command frame transmitter core.
`timescale 1ns / 1ps

module tb;
   import scft_pkg::*;

   localparam int QuietLimit = 2000;
   localparam int HoldCycles = 64;

   typedef struct packed {
      logic func;
      logic [ByteWidth-1:0] command;
      logic [ByteWidth-1:0] param_byte;
   } frame_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = FuncTick;
   logic [ByteWidth-1:0] req_command = '0;
   logic [ByteWidth-1:0] req_parameter_req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_tx_line;
   logic rsp_busy_res;
   logic rsp_accepted;
   logic rsp_frame_done;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   serial_command_frame_transmitter_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_command(req_command),
      .req_parameter_req(req_parameter_req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_line(rsp_tx_line),
      .rsp_busy_res(rsp_busy_res),
      .rsp_accepted(rsp_accepted),
      .rsp_frame_done(rsp_frame_done),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   frame_request_type request_backlog[$];
   result_type line_expect_q[$];
   frame_request_type next_request;
   result_type want;
   int errors_seen = 0;
   int send_gap = 0;
   int take_gap = 0;
   int send_idle_max = 0;
   int take_idle_max = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;
   logic long_hold = 1'b0;

   timing_type line_timing;
   logic line_busy;
   logic [PosWidth-1:0] line_pos;
   logic [PhaseWidth-1:0] line_phase;
   logic [TickWidth-1:0] line_count;
   logic [ByteWidth-1:0] line_shift;
   logic [ByteWidth-1:0] line_cmd;
   logic [ByteWidth-1:0] line_prm;
   logic line_level;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [ByteWidth-1:0] byte_at(input logic [PosWidth-1:0] pos);
      case (pos)
         FirstByte: return FrameSync;
         3'd1: return FrameVersion;
         3'd2: return FrameLength;
         3'd3: return line_cmd;
         3'd4: return FrameZero;
         3'd5: return FrameZero;
         3'd6: return line_prm;
         default: return FrameEnd;
      endcase
   endfunction

   function automatic logic [TickWidth-1:0] hold_ticks(input logic [TickWidth-1:0] value);
      return (value == '0) ? TickWidth'(1) : value;
   endfunction

   function automatic logic [TickWidth-1:0] phase_ticks(input logic [PhaseWidth-1:0] phase);
      if (phase == PhaseStart) begin
         return hold_ticks(line_timing.start_ticks);
      end else if (phase <= PhaseLastData) begin
         return hold_ticks(line_timing.bit_ticks);
      end
      return hold_ticks(line_timing.stop_ticks);
   endfunction

   function automatic void reset_line_model();
      line_timing = '{TicksReset, TicksReset, TicksReset};
      line_busy = 1'b0;
      line_pos = FirstByte;
      line_phase = PhaseStart;
      line_count = '0;
      line_shift = '0;
      line_cmd = '0;
      line_prm = '0;
      line_level = 1'b1;
   endfunction

   function automatic result_type advance_frame(input logic func,
                                                input logic [ByteWidth-1:0] cmd,
                                                input logic [ByteWidth-1:0] prm);
      result_type r;
      r = '0;
      if (func == FuncSend) begin
         if (!line_busy) begin
            line_cmd = cmd;
            line_prm = prm;
            line_busy = 1'b1;
            line_pos = FirstByte;
            line_phase = PhaseStart;
            line_count = '0;
            line_shift = byte_at(FirstByte);
            line_level = 1'b0;
            r.accepted = 1'b1;
         end
      end else if (line_busy) begin
         line_count = line_count + 1'b1;
         if (line_count >= phase_ticks(line_phase)) begin
            line_count = '0;
            if (line_phase == PhaseStart) begin
               line_phase = PhaseFirstData;
               line_level = line_shift[0];
            end else if (line_phase < PhaseLastData) begin
               line_shift = line_shift >> 1;
               line_phase = line_phase + 1'b1;
               line_level = line_shift[0];
            end else if (line_phase == PhaseLastData) begin
               line_shift = line_shift >> 1;
               line_phase = PhaseStop;
               line_level = 1'b1;
            end else if (line_pos >= LastByte) begin
               line_busy = 1'b0;
               line_pos = FirstByte;
               line_phase = PhaseStart;
               line_level = 1'b1;
               r.frame_done = 1'b1;
            end else begin
               line_pos = line_pos + 1'b1;
               line_shift = byte_at(line_pos);
               line_phase = PhaseStart;
               line_level = 1'b0;
            end
         end
      end
      r.tx_line = line_level;
      r.busy_res = line_busy;
      return r;
   endfunction

   function automatic int frame_span();
      return 8 * (int'(hold_ticks(line_timing.start_ticks))
                  + 8 * int'(hold_ticks(line_timing.bit_ticks))
                  + int'(hold_ticks(line_timing.stop_ticks)));
   endfunction

   function automatic void queue_item(input logic func);
      request_backlog.push_back('{func, ByteWidth'($urandom), ByteWidth'($urandom)});
   endfunction

   function automatic void compare_field(input string name, input logic exp_bit,
                                         input logic got_bit);
      if (got_bit !== exp_bit) begin
         $error("%s: expected %0d, got %0d", name, exp_bit, got_bit);
         errors_seen++;
      end
   endfunction

   // Mostly whole frames: a send followed by enough ticks to finish it, with some frames
   // cut short, some long idle spans and stray sends that land while a frame is running.
   task automatic queue_traffic(input int n);
      int queued;
      int span;
      int k;
      queued = 0;
      while (queued < n) begin
         queue_item(FuncSend);
         queued++;
         span = frame_span();
         case ($urandom_range(0, 9))
            0: span = $urandom_range(0, span);
            1: span = span + $urandom_range(0, 20);
            default: span = span + $urandom_range(0, 2);
         endcase
         for (k = 0; k < span && queued < n; k++) begin
            queue_item(($urandom_range(0, 49) == 0) ? FuncSend : FuncTick);
            queued++;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || line_expect_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic csr_transfer(input reg_index_type idx, input logic is_write,
                               input logic [TickWidth-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CsrDataWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (is_write) begin
         case (idx)
            REG_START_TICKS: line_timing.start_ticks = value;
            REG_BIT_TICKS: line_timing.bit_ticks = value;
            default: line_timing.stop_ticks = value;
         endcase
      end else if (csr_prdata[TickWidth-1:0] !== value) begin
         $error("%s: expected %0d, got %0d", idx.name(), value, csr_prdata[TickWidth-1:0]);
         errors_seen++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic run_timing(input logic [TickWidth-1:0] start_val,
                             input logic [TickWidth-1:0] bit_val,
                             input logic [TickWidth-1:0] stop_val,
                             input int n, input int send_idle, input int take_idle);
      wait_drained();
      csr_transfer(REG_START_TICKS, 1'b1, start_val);
      csr_transfer(REG_BIT_TICKS, 1'b1, bit_val);
      csr_transfer(REG_STOP_TICKS, 1'b1, stop_val);
      csr_transfer(REG_START_TICKS, 1'b0, start_val);
      csr_transfer(REG_BIT_TICKS, 1'b0, bit_val);
      csr_transfer(REG_STOP_TICKS, 1'b0, stop_val);
      send_idle_max <= send_idle;
      take_idle_max <= take_idle;
      @(negedge clock);
      queue_traffic(n);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            next_request = request_backlog.pop_front();
            req_func <= next_request.func;
            req_command <= next_request.command;
            req_parameter_req <= next_request.param_byte;
            req_valid <= 1'b1;
            send_gap = $urandom_range(0, send_idle_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            take_gap = $urandom_range(0, take_idle_max);
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (take_gap != 0) begin
            take_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         hold_done <= 1'b0;
         hold_left = 0;
      end else if (long_hold) begin
         hold_left--;
         if (hold_left == 0) begin
            long_hold <= 1'b0;
            hold_done <= 1'b1;
         end
      end else if (hold_armed && !hold_done) begin
         long_hold <= 1'b1;
         hold_left = HoldCycles;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            line_expect_q.push_back(advance_frame(req_func, req_command, req_parameter_req));
         end
         if (rsp_valid && !rsp_stall) begin
            if (line_expect_q.size() == 0) begin
               $error("Result arrived with no request outstanding.");
               errors_seen++;
            end else begin
               want = line_expect_q.pop_front();
               compare_field("tx_line", want.tx_line, rsp_tx_line);
               compare_field("busy_res", want.busy_res, rsp_busy_res);
               compare_field("accepted", want.accepted, rsp_accepted);
               compare_field("frame_done", want.frame_done, rsp_frame_done);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset_line_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      request_backlog.push_back('{FuncTick, 8'hFF, 8'hFF});
      request_backlog.push_back('{FuncTick, 8'h00, 8'h00});
      request_backlog.push_back('{FuncSend, 8'hFF, 8'h00});
      request_backlog.push_back('{FuncSend, 8'h00, 8'hFF});
      repeat (14) queue_item(FuncTick);
      run_timing(16'd1, 16'd1, 16'd1, 400, 0, 3);
      hold_armed <= 1'b1;
      run_timing(16'd0, 16'd0, 16'd0, 250, 3, 0);
      run_timing(16'd2, 16'd1, 16'd3, 250, 3, 3);
      run_timing(16'hFFFF, 16'd1, 16'd1, 40, 1, 1);
      run_timing(16'd1, 16'hFFFF, 16'd1, 40, 0, 2);
      run_timing(16'd1, 16'd1, 16'hFFFF, 150, 2, 0);
      run_timing(16'd3, 16'd2, 16'd1, 250, 0, 0);
      run_timing(TickWidth'($urandom_range(1, 4)), TickWidth'($urandom_range(1, 4)),
                 TickWidth'($urandom_range(1, 4)), 230, 3, 3);
      run_timing(TickWidth'($urandom_range(1, 4)), TickWidth'($urandom_range(1, 4)),
                 TickWidth'($urandom_range(1, 4)), 230, 0, 3);
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors_seen == 0 && line_expect_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/scft_pkg.sv
rtl/core/scft_csr.sv
rtl/core/scft_engine.sv
rtl/core/scft_outq.sv
rtl/core/serial_command_frame_transmitter_core.sv
test/tb.sv
